[rtl/subarray_scatter_cache_core_macros.svh]
// Assertion macros shared by the store and address generator modules.
`ifndef SUBARRAY_SCATTER_CACHE_CORE_MACROS_SVH
`define SUBARRAY_SCATTER_CACHE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSC_ASSERT_AT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ssc_pkg.sv]
package ssc_pkg;

    // Store geometry.
    localparam int unsigned STORE_DEPTH = 4096;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
    localparam int unsigned IDX_W       = 41;
    localparam logic [IDX_W-1:0]  STORE_LAST = IDX_W'(STORE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [31:0]       QNAN_WORD  = 32'h7FC0_0000;
    localparam logic [12:0]       MAX_EXTENT = 13'd4096;

    // Configuration port.
    localparam int unsigned PADDR_W = 4;
    localparam logic [1:0] REG_DIM_I = 2'd0;
    localparam logic [1:0] REG_DIM_J = 2'd1;
    localparam logic [1:0] REG_DIM_K = 2'd2;
    localparam logic [12:0] DIM_RESET = 13'd16;

    // Transaction modes on the input channel.
    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_ELEM  = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    // Array dimensions after clamping to the legal range.
    typedef struct packed {
        logic [12:0] di;
        logic [12:0] dj;
        logic [12:0] dk;
    } dims_t;

    // Write request from the address generator to the store.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
    } wr_req_t;

    // Store status seen by the input handshake.
    typedef struct packed {
        logic sweeping;
        logic rd_pending;
    } store_status_t;

    // A dimension of zero acts as one, and anything above 4096 acts as 4096.
    function automatic logic [12:0] clamp_dim(logic [12:0] d);
        logic [12:0] r;
        r = d;
        if (d == 13'd0) begin
            r = 13'd1;
        end else if (d > MAX_EXTENT) begin
            r = MAX_EXTENT;
        end
        return r;
    endfunction

    // Block extents saturate at 4096.
    function automatic logic [12:0] clamp_extent(logic [12:0] e);
        return (e > MAX_EXTENT) ? MAX_EXTENT : e;
    endfunction

    // Any index at or past the end of the store maps to the last entry.
    function automatic logic [ADDR_W-1:0] clamp_store(logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        r = (idx > STORE_LAST) ? STORE_LAST : idx;
        return r[ADDR_W-1:0];
    endfunction

endpackage

[rtl/ssc_cfg_regs.sv]
module ssc_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ssc_pkg::dims_t              dims
);
    import ssc_pkg::*;

    logic [12:0] dim_i_reg;
    logic [12:0] dim_j_reg;
    logic [12:0] dim_k_reg;
    logic [1:0]  reg_sel;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes complete in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_i_reg <= DIM_RESET;
            dim_j_reg <= DIM_RESET;
            dim_k_reg <= DIM_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_DIM_I: dim_i_reg <= pwdata[12:0];
                REG_DIM_J: dim_j_reg <= pwdata[12:0];
                REG_DIM_K: dim_k_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // Reads return the raw register contents.
    always_comb begin
        case (reg_sel)
            REG_DIM_I: prdata = {19'd0, dim_i_reg};
            REG_DIM_J: prdata = {19'd0, dim_j_reg};
            REG_DIM_K: prdata = {19'd0, dim_k_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // The datapath only ever sees dimensions in the legal range.
    assign dims = '{di: clamp_dim(dim_i_reg), dj: clamp_dim(dim_j_reg),
                    dk: clamp_dim(dim_k_reg)};

endmodule

[rtl/ssc_addr_gen.sv]
`include "subarray_scatter_cache_core_macros.svh"

module ssc_addr_gen (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start_fire,
    input  logic             elem_fire,
    input  logic [31:0]      value,
    input  logic [12:0]      put_i,
    input  logic [12:0]      put_j,
    input  logic [12:0]      put_k,
    input  logic [11:0]      off_i,
    input  logic [11:0]      off_j,
    input  logic [11:0]      off_k,
    input  ssc_pkg::dims_t   dims,
    output ssc_pkg::wr_req_t wr,
    output logic             busy
);
    import ssc_pkg::*;

    // Block descriptor and position counters.
    logic [12:0] ext_i_reg, ext_j_reg, ext_k_reg;
    logic [11:0] off_i_reg, off_j_reg, off_k_reg;
    logic [11:0] cnt_i_reg, cnt_j_reg, cnt_k_reg;
    logic        active_reg;

    // Stage 1: absolute coordinates.
    logic        s1_valid_reg;
    logic [12:0] s1_oi_reg, s1_oj_reg, s1_ok_reg;
    dims_t       s1_dims_reg;
    logic [31:0] s1_data_reg;

    // Stage 2: outer product and partial array size.
    logic        s2_valid_reg;
    logic [25:0] s2_p_reg, s2_sz_reg;
    logic [12:0] s2_oj_reg, s2_ok_reg, s2_dk_reg;
    logic [31:0] s2_data_reg;

    // Stage 3: scaled row index and full array size.
    logic             s3_valid_reg;
    logic [IDX_W-1:0] s3_prod_reg, s3_size_reg;
    logic [12:0]      s3_ok_reg;
    logic [31:0]      s3_data_reg;

    // Stage 4: clamped write request.
    logic              wr_valid_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [31:0]       wr_data_reg;

    logic [12:0]      cnt_i_inc, cnt_j_inc, cnt_k_inc;
    logic             wrap_i, wrap_j, wrap_k;
    logic [26:0]      row_sum;
    logic [IDX_W-1:0] idx_full, size_last, idx_arr;
    logic [ADDR_W-1:0] wr_addr_next;

    assign cnt_i_inc = {1'b0, cnt_i_reg} + 13'd1;
    assign cnt_j_inc = {1'b0, cnt_j_reg} + 13'd1;
    assign cnt_k_inc = {1'b0, cnt_k_reg} + 13'd1;
    assign wrap_i    = cnt_i_inc >= ext_i_reg;
    assign wrap_j    = cnt_j_inc >= ext_j_reg;
    assign wrap_k    = cnt_k_inc >= ext_k_reg;

    // Block state and the valid bits of the index pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_i_reg    <= '0;
            ext_j_reg    <= '0;
            ext_k_reg    <= '0;
            off_i_reg    <= '0;
            off_j_reg    <= '0;
            off_k_reg    <= '0;
            cnt_i_reg    <= '0;
            cnt_j_reg    <= '0;
            cnt_k_reg    <= '0;
            active_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end else begin
            if (start_fire) begin
                ext_i_reg  <= clamp_extent(put_i);
                ext_j_reg  <= clamp_extent(put_j);
                ext_k_reg  <= clamp_extent(put_k);
                off_i_reg  <= off_i;
                off_j_reg  <= off_j;
                off_k_reg  <= off_k;
                cnt_i_reg  <= '0;
                cnt_j_reg  <= '0;
                cnt_k_reg  <= '0;
                active_reg <= (put_i != 13'd0) && (put_j != 13'd0) && (put_k != 13'd0);
            end else if (elem_fire && active_reg) begin
                // Row-major walk, innermost dimension fastest.
                if (!wrap_k) begin
                    cnt_k_reg <= cnt_k_inc[11:0];
                end else begin
                    cnt_k_reg <= '0;
                    if (!wrap_j) begin
                        cnt_j_reg <= cnt_j_inc[11:0];
                    end else begin
                        cnt_j_reg <= '0;
                        if (!wrap_i) begin
                            cnt_i_reg <= cnt_i_inc[11:0];
                        end else begin
                            cnt_i_reg  <= '0;
                            active_reg <= 1'b0;
                        end
                    end
                end
            end
            s1_valid_reg <= elem_fire && active_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            wr_valid_reg <= s3_valid_reg;
        end
    end

    // Final index: add the inner offset, clamp to the array, then to the store.
    assign row_sum      = {1'b0, s2_p_reg} + {14'd0, s2_oj_reg};
    assign idx_full     = s3_prod_reg + IDX_W'(s3_ok_reg);
    assign size_last    = s3_size_reg - IDX_W'(1);
    assign idx_arr      = (idx_full > size_last) ? size_last : idx_full;
    assign wr_addr_next = clamp_store(idx_arr);

    // Index pipeline payload; at most one multiplier per path per stage.
    always_ff @(posedge aclk) begin
        s1_oi_reg   <= {1'b0, off_i_reg} + {1'b0, cnt_i_reg};
        s1_oj_reg   <= {1'b0, off_j_reg} + {1'b0, cnt_j_reg};
        s1_ok_reg   <= {1'b0, off_k_reg} + {1'b0, cnt_k_reg};
        s1_dims_reg <= dims;
        s1_data_reg <= value;

        s2_p_reg    <= {13'd0, s1_oi_reg} * {13'd0, s1_dims_reg.dj};
        s2_sz_reg   <= {13'd0, s1_dims_reg.di} * {13'd0, s1_dims_reg.dj};
        s2_oj_reg   <= s1_oj_reg;
        s2_ok_reg   <= s1_ok_reg;
        s2_dk_reg   <= s1_dims_reg.dk;
        s2_data_reg <= s1_data_reg;

        s3_prod_reg <= IDX_W'(row_sum) * IDX_W'(s2_dk_reg);
        s3_size_reg <= IDX_W'(s2_sz_reg) * IDX_W'(s2_dk_reg);
        s3_ok_reg   <= s2_ok_reg;
        s3_data_reg <= s2_data_reg;

        wr_addr_reg <= wr_addr_next;
        wr_data_reg <= s3_data_reg;
    end

    assign wr   = '{valid: wr_valid_reg, addr: wr_addr_reg, data: wr_data_reg};
    assign busy = s1_valid_reg || s2_valid_reg || s3_valid_reg || wr_valid_reg;

    `SSC_ASSERT_NEXT(a_elem_enters, aclk, aresetn, elem_fire && active_reg, s1_valid_reg, "accepted element did not enter the index pipeline")
    `SSC_ASSERT_NEXT(a_start_clears, aclk, aresetn, start_fire, cnt_i_reg == 12'd0 && cnt_j_reg == 12'd0 && cnt_k_reg == 12'd0, "start did not clear the block counters")
    `SSC_ASSERT_AT(a_wr_in_range, aclk, aresetn, wr_valid_reg, wr_addr_reg <= SWEEP_LAST, "write address beyond the store")

endmodule

[rtl/ssc_store.sv]
`include "subarray_scatter_cache_core_macros.svh"

module ssc_store (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ssc_pkg::wr_req_t       wr,
    input  logic                   flush_fire,
    input  logic                   read_fire,
    input  logic [11:0]            read_addr,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [31:0]            m_read_value,
    output logic [11:0]            m_read_index,
    output ssc_pkg::store_status_t status
);
    import ssc_pkg::*;

    typedef enum logic {
        ST_SWEEP,
        ST_RUN
    } state_t;

    logic [31:0] mem [STORE_DEPTH];

    state_t            state_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;
    logic              rd_pending_reg;
    logic              m_valid_reg;
    logic [31:0]       m_value_reg;
    logic [11:0]       m_index_reg;
    logic [31:0]       mem_q;
    logic [11:0]       idx_q;

    logic              out_free;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;

    assign out_free = !m_valid_reg || m_ready;

    // The sweep owns the write port; element writes only arrive outside it.
    always_comb begin
        if (state_reg == ST_SWEEP) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_reg;
            mem_wdata = QNAN_WORD;
        end else begin
            mem_we    = wr.valid;
            mem_waddr = wr.addr;
            mem_wdata = wr.data;
        end
    end

    // Single write port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Single read port, registered data.
    always_ff @(posedge aclk) begin
        if (read_fire) begin
            mem_q <= mem[clamp_store(IDX_W'(read_addr))];
            idx_q <= read_addr;
        end
    end

    // Sweep sequencer and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            sweep_cnt_reg  <= '0;
            rd_pending_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            case (state_reg)
                ST_SWEEP: begin
                    if (sweep_cnt_reg == SWEEP_LAST) begin
                        state_reg     <= ST_RUN;
                        sweep_cnt_reg <= '0;
                    end else begin
                        sweep_cnt_reg <= sweep_cnt_reg + ADDR_W'(1);
                    end
                end
                ST_RUN: begin
                    if (flush_fire) begin
                        state_reg <= ST_SWEEP;
                    end
                end
                default: state_reg <= ST_SWEEP;
            endcase

            if (read_fire) begin
                rd_pending_reg <= 1'b1;
            end else if (out_free) begin
                rd_pending_reg <= 1'b0;
            end

            if (rd_pending_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (rd_pending_reg && out_free) begin
            m_value_reg <= mem_q;
            m_index_reg <= idx_q;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_value_reg;
    assign m_read_index = m_index_reg;
    assign status       = '{sweeping: state_reg == ST_SWEEP, rd_pending: rd_pending_reg};

    `SSC_ASSERT_AT(a_read_idle, aclk, aresetn, read_fire, !rd_pending_reg && state_reg == ST_RUN, "read accepted while busy")
    `SSC_ASSERT_AT(a_wr_run, aclk, aresetn, wr.valid, state_reg == ST_RUN, "element write collided with a sweep")
    `SSC_ASSERT_NEXT(a_result_moves, aclk, aresetn, rd_pending_reg && out_free, m_valid_reg, "pending read did not reach the output")

endmodule

[rtl/subarray_scatter_cache_core.sv]
// Channel   Handshake        Carries
// s_*       s_valid/s_ready  mode, value, extents, offsets, read address
// m_*       m_valid/m_ready  read value and read index
// apb       psel/penable     dim_i, dim_j, dim_k at byte addresses 0, 4, 8
//
// Start and element transactions are taken whenever no sweep runs; an element write lands in the
// store at the end of the index pipeline.
// A read or flush waits until those writes have landed, and the read data passes through a
// registered store read into the result register once the output is free.
// Reset and every flush sweep quiet NaN into the store, with no transaction taken; a
// stalled result lets one more read in and then holds off reads only.
module subarray_scatter_cache_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic [31:0]                 s_value,
    input  logic [12:0]                 s_put_i,
    input  logic [12:0]                 s_put_j,
    input  logic [12:0]                 s_put_k,
    input  logic [11:0]                 s_off_i,
    input  logic [11:0]                 s_off_j,
    input  logic [11:0]                 s_off_k,
    input  logic [11:0]                 s_read_addr,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [31:0]                 m_read_value,
    output logic [11:0]                 m_read_index,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ssc_pkg::*;

    dims_t         dims;
    wr_req_t       wr;
    store_status_t st_status;
    logic          pipe_busy;
    logic          s_fire;
    logic          start_fire, elem_fire, flush_fire, read_fire;

    // Reads and flushes wait for in-flight element writes to land.
    always_comb begin
        case (s_mode)
            MODE_READ:  s_ready = !st_status.sweeping && !pipe_busy && !st_status.rd_pending;
            MODE_FLUSH: s_ready = !st_status.sweeping && !pipe_busy;
            default:    s_ready = !st_status.sweeping;
        endcase
    end

    assign s_fire     = s_valid && s_ready;
    assign start_fire = s_fire && (s_mode == MODE_START);
    assign elem_fire  = s_fire && (s_mode == MODE_ELEM);
    assign flush_fire = s_fire && (s_mode == MODE_FLUSH);
    assign read_fire  = s_fire && (s_mode == MODE_READ);

    ssc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims)
    );

    ssc_addr_gen u_addr_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_fire (start_fire),
        .elem_fire  (elem_fire),
        .value      (s_value),
        .put_i      (s_put_i),
        .put_j      (s_put_j),
        .put_k      (s_put_k),
        .off_i      (s_off_i),
        .off_j      (s_off_j),
        .off_k      (s_off_k),
        .dims       (dims),
        .wr         (wr),
        .busy       (pipe_busy)
    );

    ssc_store u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr           (wr),
        .flush_fire   (flush_fire),
        .read_fire    (read_fire),
        .read_addr    (s_read_addr),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_read_value (m_read_value),
        .m_read_index (m_read_index),
        .status       (st_status)
    );

endmodule

[verif/scatter_cache_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the scatter cache, keeps
// a shadow copy of the store, and compares every read result in order.
module scatter_cache_checker
    import ssc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic [31:0]         s_value,
    input  logic [12:0]         s_put_i,
    input  logic [12:0]         s_put_j,
    input  logic [12:0]         s_put_k,
    input  logic [11:0]         s_off_i,
    input  logic [11:0]         s_off_j,
    input  logic [11:0]         s_off_k,
    input  logic [11:0]         s_read_addr,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [31:0]         m_read_value,
    input  logic [11:0]         m_read_index,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  mismatch_count,
    output int                  pending_reads,
    output int                  reads_checked
);

    // One expected read result.
    typedef struct packed {
        logic [31:0] word;
        logic [11:0] index;
    } read_word_t;

    read_word_t  expected_reads[$];
    logic [31:0] shadow_store [STORE_DEPTH];

    // Shadow of the configuration and of the open block.
    logic [12:0] dim_i, dim_j, dim_k;
    logic [12:0] ext_i, ext_j, ext_k;
    logic [11:0] org_i, org_j, org_k;
    logic [12:0] cnt_i, cnt_j, cnt_k;
    logic        block_open;

    // A dimension of zero behaves as one; anything above 4096 behaves as 4096.
    function automatic logic [63:0] usable_dim(logic [12:0] d);
        if (d == 13'd0) begin
            return 64'd1;
        end
        return (d > 13'd4096) ? 64'd4096 : 64'(d);
    endfunction

    function automatic logic [12:0] sat_extent(logic [12:0] e);
        return (e > 13'd4096) ? 13'd4096 : e;
    endfunction

    always @(posedge aclk) begin : model_step
        logic [63:0] dj, dk, span, lin;
        read_word_t  want;

        if (!aresetn) begin
            for (int n = 0; n < STORE_DEPTH; n++) begin
                shadow_store[n] = QNAN_WORD;
            end
            expected_reads.delete();
            dim_i = 13'd16;
            dim_j = 13'd16;
            dim_k = 13'd16;
            ext_i = '0;
            ext_j = '0;
            ext_k = '0;
            org_i = '0;
            org_j = '0;
            org_k = '0;
            cnt_i = '0;
            cnt_j = '0;
            cnt_k = '0;
            block_open = 1'b0;
            mismatch_count = 0;
            reads_checked = 0;
        end else begin
            // Compare a read result transaction with the oldest expectation.
            if (m_valid && m_ready) begin
                if (expected_reads.size() == 0) begin
                    $display("%0t: unexpected read result, expected none, actual value %h index %0d",
                             $time, m_read_value, m_read_index);
                    mismatch_count++;
                end else begin
                    want = expected_reads.pop_front();
                    reads_checked++;
                    if (m_read_value !== want.word) begin
                        $display("%0t: read_value mismatch, expected %h, actual %h",
                                 $time, want.word, m_read_value);
                        mismatch_count++;
                    end
                    if (m_read_index !== want.index) begin
                        $display("%0t: read_index mismatch, expected %0d, actual %0d",
                                 $time, want.index, m_read_index);
                        mismatch_count++;
                    end
                end
            end

            // Track dimension register writes.
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_DIM_I: dim_i = pwdata[12:0];
                    REG_DIM_J: dim_j = pwdata[12:0];
                    REG_DIM_K: dim_k = pwdata[12:0];
                    default: ;
                endcase
            end

            // Apply an accepted input transaction to the shadow store.
            if (s_valid && s_ready) begin
                case (s_mode)
                    MODE_START: begin
                        ext_i = sat_extent(s_put_i);
                        ext_j = sat_extent(s_put_j);
                        ext_k = sat_extent(s_put_k);
                        org_i = s_off_i;
                        org_j = s_off_j;
                        org_k = s_off_k;
                        cnt_i = '0;
                        cnt_j = '0;
                        cnt_k = '0;
                        block_open = (ext_i != 0) && (ext_j != 0) && (ext_k != 0);
                    end
                    MODE_ELEM: begin
                        if (block_open) begin
                            dj = usable_dim(dim_j);
                            dk = usable_dim(dim_k);
                            span = usable_dim(dim_i) * dj * dk;
                            lin = ((64'(org_i) + 64'(cnt_i)) * dj + 64'(org_j) + 64'(cnt_j)) * dk
                                  + 64'(org_k) + 64'(cnt_k);
                            if (lin > span - 64'd1) begin
                                lin = span - 64'd1;
                            end
                            if (lin >= 64'(STORE_DEPTH)) begin
                                lin = 64'(STORE_DEPTH - 1);
                            end
                            shadow_store[lin[ADDR_W-1:0]] = s_value;

                            // Row-major walk, innermost dimension fastest.
                            cnt_k++;
                            if (cnt_k >= ext_k) begin
                                cnt_k = '0;
                                cnt_j++;
                                if (cnt_j >= ext_j) begin
                                    cnt_j = '0;
                                    cnt_i++;
                                    if (cnt_i >= ext_i) begin
                                        cnt_i = '0;
                                        block_open = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                    MODE_FLUSH: begin
                        for (int n = 0; n < STORE_DEPTH; n++) begin
                            shadow_store[n] = QNAN_WORD;
                        end
                    end
                    default: begin
                        want.word  = shadow_store[s_read_addr];
                        want.index = s_read_addr;
                        expected_reads.push_back(want);
                    end
                endcase
            end
        end
        pending_reads = expected_reads.size();
    end

endmodule

[verif/tb_subarray_scatter_cache_core.sv]
`timescale 1ns / 1ps

module tb_subarray_scatter_cache_core;
    import ssc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASES       = 8;
    localparam int HOLD_CYCLES  = 400;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [1:0]          s_mode      = MODE_READ;
    logic [31:0]         s_value     = '0;
    logic [12:0]         s_put_i     = '0;
    logic [12:0]         s_put_j     = '0;
    logic [12:0]         s_put_k     = '0;
    logic [11:0]         s_off_i     = '0;
    logic [11:0]         s_off_j     = '0;
    logic [11:0]         s_off_k     = '0;
    logic [11:0]         s_read_addr = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [31:0]         m_read_value;
    logic [11:0]         m_read_index;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;

    int mismatch_count;
    int pending_reads;
    int reads_checked;

    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int noise_items    = 0;
    int shapes_used    = 0;
    int span_hint      = STORE_DEPTH;
    bit last_was_flush = 1'b0;

    subarray_scatter_cache_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_value      (s_value),
        .s_put_i      (s_put_i),
        .s_put_j      (s_put_j),
        .s_put_k      (s_put_k),
        .s_off_i      (s_off_i),
        .s_off_j      (s_off_j),
        .s_off_k      (s_off_k),
        .s_read_addr  (s_read_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_read_index (m_read_index),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    scatter_cache_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_value        (s_value),
        .s_put_i        (s_put_i),
        .s_put_j        (s_put_j),
        .s_put_k        (s_put_k),
        .s_off_i        (s_off_i),
        .s_off_j        (s_off_j),
        .s_off_k        (s_off_k),
        .s_read_addr    (s_read_addr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_value   (m_read_value),
        .m_read_index   (m_read_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .pending_reads  (pending_reads),
        .reads_checked  (reads_checked)
    );

    // Free-running 50 MHz clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Abort the run if it goes far beyond the slowest legal schedule.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (hold_request != hold_served) begin
            hold_served = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offer one input transaction and hold it until it is accepted.
    task automatic send_txn(input mode_t md, input logic [31:0] val,
                            input logic [12:0] pi, input logic [12:0] pj,
                            input logic [12:0] pk, input logic [11:0] oi,
                            input logic [11:0] oj, input logic [11:0] ok,
                            input logic [11:0] ra);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_mode      = md;
        s_value     = val;
        s_put_i     = pi;
        s_put_j     = pj;
        s_put_k     = pk;
        s_off_i     = oi;
        s_off_j     = oj;
        s_off_k     = ok;
        s_read_addr = ra;
        s_valid     = 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        last_was_flush = (md == MODE_FLUSH);
        @(negedge aclk);
    endtask

    // Fields that the mode does not use carry random bits.
    task automatic send_start(input logic [12:0] pi, input logic [12:0] pj,
                              input logic [12:0] pk, input logic [11:0] oi,
                              input logic [11:0] oj, input logic [11:0] ok);
        send_txn(MODE_START, $urandom, pi, pj, pk, oi, oj, ok, 12'($urandom));
    endtask

    task automatic send_elem(input logic [31:0] val);
        send_txn(MODE_ELEM, val, 13'($urandom), 13'($urandom), 13'($urandom),
                 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    endtask

    task automatic send_flush();
        send_txn(MODE_FLUSH, $urandom, 13'($urandom), 13'($urandom), 13'($urandom),
                 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    endtask

    task automatic send_read(input logic [11:0] ra);
        send_txn(MODE_READ, $urandom, 13'($urandom), 13'($urandom), 13'($urandom),
                 12'($urandom), 12'($urandom), 12'($urandom), ra);
    endtask

    // Wait until every read has returned and the last writes or sweep have landed.
    task automatic drain();
        s_valid = 1'b0;
        while (pending_reads != 0) begin
            @(negedge aclk);
        end
        repeat (last_was_flush ? STORE_DEPTH + 16 : 16) @(negedge aclk);
    endtask

    // Register write: setup, then access.
    task automatic write_dim(input logic [1:0] reg_idx, input logic [12:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({reg_idx, 2'b00});
        pwdata  = 32'(val);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic longint usable_dim(logic [12:0] d);
        if (d == 13'd0) begin
            return 1;
        end
        return (d > 13'd4096) ? 4096 : longint'(d);
    endfunction

    // Program the array shape and note how much of the store it can reach.
    task automatic set_shape(input logic [12:0] di, input logic [12:0] dj,
                             input logic [12:0] dk);
        longint cells;
        write_dim(REG_DIM_I, di);
        write_dim(REG_DIM_J, dj);
        write_dim(REG_DIM_K, dk);
        cells = usable_dim(di) * usable_dim(dj) * usable_dim(dk);
        span_hint = (cells > STORE_DEPTH) ? STORE_DEPTH : int'(cells);
        shapes_used++;
    endtask

    // Reads favor the low corner of the array, where small blocks land.
    function automatic logic [11:0] pick_addr();
        int r;
        int hi;
        r = $urandom_range(0, 99);
        hi = (span_hint < 64) ? span_hint - 1 : 63;
        if (r < 55) begin
            return 12'($urandom_range(0, hi));
        end else if (r < 80) begin
            return 12'($urandom_range(0, span_hint - 1));
        end else if (r < 90) begin
            return 12'(STORE_DEPTH - 1);
        end
        return 12'($urandom);
    endfunction

    function automatic logic [11:0] pick_offset();
        if ($urandom_range(0, 99) < 85) begin
            return 12'($urandom_range(0, 3));
        end
        return 12'($urandom);
    endfunction

    // One start transaction, its elements with reads and occasional flushes mixed in, then some reads.
    task automatic random_block();
        logic [12:0] ei, ej, ek;
        int shape;
        int n_elem;
        bit empty_block;
        shape = $urandom_range(0, 99);
        empty_block = 1'b0;
        ei = 13'($urandom_range(1, 4));
        ej = 13'($urandom_range(1, 4));
        ek = 13'($urandom_range(1, 4));
        n_elem = ei * ej * ek;
        if (shape < 4) begin
            empty_block = 1'b1;
            case ($urandom_range(0, 2))
                0: ei = '0;
                1: ej = '0;
                default: ek = '0;
            endcase
            n_elem = $urandom_range(0, 2);
        end else if (shape < 9) begin
            ei = ($urandom_range(0, 1) != 0) ? 13'h1FFF : 13'($urandom_range(1, 8191));
            ej = 13'($urandom_range(1, 8191));
            ek = ($urandom_range(0, 1) != 0) ? 13'd4096 : 13'($urandom_range(1, 8191));
            n_elem = $urandom_range(1, 16);
        end
        send_start(ei, ej, ek, pick_offset(), pick_offset(), pick_offset());
        for (int n = 0; n < n_elem; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                send_read(pick_addr());
            end
            if ($urandom_range(0, 199) == 0) begin
                send_flush();
            end
            // Cutting a block short lets the next start replace it.
            if ($urandom_range(0, 99) < 3) begin
                break;
            end
            send_elem($urandom);
            if (empty_block) begin
                noise_items++;
            end
        end
        // A stray element after the loop is dropped if the block is already complete.
        if ($urandom_range(0, 3) == 0) begin
            send_elem($urandom);
            noise_items++;
        end
        repeat ($urandom_range(1, 3)) send_read(pick_addr());
    endtask

    initial begin : stimulus
        int phase_goal;

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part with the reset shape of 16 x 16 x 16.
        send_read(12'd0);
        send_start(13'd2, 13'd2, 13'd2, 12'd0, 12'd0, 12'd0);
        send_elem(32'h0000_0000);
        send_elem(32'hFFFF_FFFF);
        repeat (6) send_elem($urandom);
        send_elem(32'hDEAD_BEEF);
        send_read(12'd0);
        send_read(12'd273);
        // A start with a zero extent opens nothing, so the element is dropped.
        send_start(13'd0, 13'd3, 13'd3, 12'd0, 12'd0, 12'd0);
        send_elem(32'h1234_5678);
        // Oversized extents saturate and the far index clamps to the last word.
        send_start(13'h1FFF, 13'h1FFF, 13'h1FFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_elem(32'hA5A5_5A5A);
        send_read(12'hFFF);
        // A new start replaces a block that is still open.
        send_start(13'd1, 13'd1, 13'd3, 12'd1, 12'd2, 12'd3);
        send_elem($urandom);
        send_start(13'd1, 13'd1, 13'd1, 12'd0, 12'd0, 12'd5);
        send_elem($urandom);
        send_read(12'd5);
        // A flush in the middle of a block leaves the block open.
        send_start(13'd1, 13'd1, 13'd2, 12'd0, 12'd1, 12'd0);
        send_elem($urandom);
        send_flush();
        send_elem($urandom);
        send_read(12'd16);
        send_read(12'd17);
        drain();

        // Random part: each phase has its own shape and idling pattern.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_shape(13'd4, 13'd8, 13'd16);
                1: set_shape(13'd0, 13'd0, 13'd0);
                2: set_shape(13'h1FFF, 13'h1FFF, 13'h1FFF);
                3: set_shape(13'd4096, 13'd1, 13'd1);
                4: set_shape(13'd1, 13'd4096, 13'd1);
                5: set_shape(13'($urandom_range(1, 16)), 13'($urandom_range(1, 16)),
                             13'($urandom_range(1, 16)));
                6: set_shape(13'd1, 13'd1, 13'd4096);
                default: set_shape(13'($urandom_range(1, 32)), 13'($urandom_range(1, 32)),
                                   13'($urandom_range(1, 32)));
            endcase
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 52;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 52;
                end
                default: begin
                    send_idle_pct = 37;
                    recv_stall_pct = 37;
                end
            endcase

            // Back up the result side so that the input stalls.
            if (ph == 2) begin
                hold_request++;
                repeat (48) send_read(pick_addr());
            end

            phase_goal = (items_sent - noise_items) + RANDOM_ITEMS / PHASES;
            while ((items_sent - noise_items) < phase_goal) begin
                if ($urandom_range(0, 99) == 0) begin
                    send_flush();
                end
                random_block();
            end
            drain();
        end

        $display("Sent %0d input transactions and checked %0d read results over %0d shapes.",
                 items_sent, reads_checked, shapes_used);
        $display("Shapes included zero, saturated and single-axis dimensions under mixed stalls.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
